// File: rtl/sacfl_pkg.sv
// ----------------------------------------------------------------------------
// sacfl_pkg
// Shared constants and types for the set-associative cache tag block with
// FIFO or LRU replacement.
// ----------------------------------------------------------------------------
package sacfl_pkg;

    localparam int WAYS_DEF        = 4;
    localparam int SETS_DEF        = 256;
    localparam int OFFSET_BITS_DEF = 4;
    localparam int ADDR_BITS_DEF   = 20;

    localparam int STAMP_BITS = 32;
    localparam int COUNT_BITS = 32;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

// File: rtl/sacfl_tag_ram.sv
// ----------------------------------------------------------------------------
// sacfl_tag_ram
// Simple dual-port synchronous memory holding one row per set: one write
// port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sacfl_tag_ram
    import sacfl_pkg::*;
#(
    parameter int DEPTH  = SETS_DEF,
    parameter int WIDTH  = WAYS_DEF * (1 + 8 + STAMP_BITS),
    parameter int ADDR_W = $clog2(SETS_DEF)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/sacfl_lookup.sv
// ----------------------------------------------------------------------------
// sacfl_lookup
// Tag compare, victim selection and row update for one set. Takes the row
// read from the tag memory and produces the hit flag, the chosen way, the
// eviction flag and the row to write back.
// ----------------------------------------------------------------------------
module sacfl_lookup
    import sacfl_pkg::*;
#(
    parameter int WAYS     = WAYS_DEF,
    parameter int TAG_BITS = 8,
    parameter int WAY_BITS = $clog2(WAYS_DEF)
)
(
    input  logic [WAYS*(1+TAG_BITS+STAMP_BITS)-1:0] rd_row,
    input  logic                                    row_init,
    input  logic [TAG_BITS-1:0]                     tag,
    input  logic                                    mode,
    input  logic [STAMP_BITS-1:0]                   now,
    output logic                                    hit,
    output logic [WAY_BITS-1:0]                     way,
    output logic                                    evict,
    output logic [WAYS*(1+TAG_BITS+STAMP_BITS)-1:0] wr_row
);

    localparam int ENTRY_BITS = 1 + TAG_BITS + STAMP_BITS;
    localparam int PAD        = 1 << WAY_BITS;

    logic                  vld   [WAYS];
    logic [TAG_BITS-1:0]   tg    [WAYS];
    logic [STAMP_BITS-1:0] st    [WAYS];
    logic [WAYS-1:0]       match;
    logic [WAY_BITS-1:0]   hit_idx;
    logic [WAY_BITS-1:0]   free_idx;
    logic                  any_free;
    logic [STAMP_BITS-1:0] node_st  [1:2*PAD-1];
    logic [WAY_BITS-1:0]   node_idx [1:2*PAD-1];

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            vld[w]   = row_init & rd_row[w*ENTRY_BITS + ENTRY_BITS - 1];
            tg[w]    = rd_row[w*ENTRY_BITS + STAMP_BITS +: TAG_BITS];
            st[w]    = rd_row[w*ENTRY_BITS +: STAMP_BITS];
            match[w] = vld[w] && (tg[w] == tag);
        end

        hit_idx  = '0;
        free_idx = '0;
        any_free = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_idx = WAY_BITS'(w);
            end
            if (!vld[w])
            begin
                free_idx = WAY_BITS'(w);
                any_free = 1'b1;
            end
        end
    end

    // The smallest stamp wins; on a tie the left (lower) way is kept.
    always_comb
    begin
        for (int i = 0; i < PAD; i++)
        begin
            node_idx[PAD + i] = WAY_BITS'(i);
            if (i < WAYS)
            begin
                node_st[PAD + i] = st[i];
            end
            else
            begin
                node_st[PAD + i] = '1;
            end
        end
        for (int n = PAD - 1; n >= 1; n--)
        begin
            if (node_st[2*n + 1] < node_st[2*n])
            begin
                node_st[n]  = node_st[2*n + 1];
                node_idx[n] = node_idx[2*n + 1];
            end
            else
            begin
                node_st[n]  = node_st[2*n];
                node_idx[n] = node_idx[2*n];
            end
        end
    end

    always_comb
    begin
        hit   = |match;
        evict = !hit && !any_free;
        if (hit)
        begin
            way = hit_idx;
        end
        else if (any_free)
        begin
            way = free_idx;
        end
        else
        begin
            way = node_idx[1];
        end

        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_BITS'(w) == way)
            begin
                if (hit)
                begin
                    if (mode == MODE_LRU)
                    begin
                        wr_row[w*ENTRY_BITS +: ENTRY_BITS] = {1'b1, tg[w], now};
                    end
                    else
                    begin
                        wr_row[w*ENTRY_BITS +: ENTRY_BITS] = {1'b1, tg[w], st[w]};
                    end
                end
                else
                begin
                    wr_row[w*ENTRY_BITS +: ENTRY_BITS] = {1'b1, tag, now};
                end
            end
            else
            begin
                wr_row[w*ENTRY_BITS +: ENTRY_BITS] = {vld[w], tg[w], st[w]};
            end
        end
    end

endmodule

// File: rtl/set_assoc_cache_fifo_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_lru
// Set-associative cache tag lookup with FIFO or LRU replacement and running
// miss and eviction totals.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  -----------------------------------------
//   in       in_valid / in_ready    access_address
//   out      out_valid / out_ready  is_hit, way_used, did_replace,
//                                   miss_total, replace_total
//   cfg      cfg_valid / cfg_ready  cfg_data (replace_mode)
//
// Each set row is read from the tag memory in ST_IDLE and written back in
// ST_LOOKUP; no item is taken before the last is written back. A result
// waits in the output register while the next item is read. The write-back
// stalls while the output register holds an untaken result. After reset
// every set reads as empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_lru
    import sacfl_pkg::*;
#(
    parameter int WAYS        = WAYS_DEF,
    parameter int SETS        = SETS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ADDR_BITS-1:0]        access_address,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_hit,
    output logic [$clog2(WAYS)-1:0]     way_used,
    output logic                        did_replace,
    output logic [COUNT_BITS-1:0]       miss_total,
    output logic [COUNT_BITS-1:0]       replace_total,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);

    localparam int WAY_BITS   = $clog2(WAYS);
    localparam int SET_BITS   = $clog2(SETS);
    localparam int TAG_BITS   = ADDR_BITS - OFFSET_BITS - SET_BITS;
    localparam int ENTRY_BITS = 1 + TAG_BITS + STAMP_BITS;
    localparam int ROW_BITS   = WAYS * ENTRY_BITS;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    replace_mode_reg;
    logic [SETS-1:0]         set_init_reg;
    logic [SET_BITS-1:0]     set_reg;
    logic [TAG_BITS-1:0]     tag_reg;
    logic [STAMP_BITS-1:0]   access_reg;
    logic [COUNT_BITS-1:0]   miss_reg;
    logic [COUNT_BITS-1:0]   evict_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    is_hit_reg;
    logic [WAY_BITS-1:0]     way_reg;
    logic                    replace_reg;
    logic                    rd_en;
    logic                    wr_en;
    logic                    load_out;
    logic [ROW_BITS-1:0]     rd_row;
    logic [ROW_BITS-1:0]     wr_row;
    logic                    lk_hit;
    logic [WAY_BITS-1:0]     lk_way;
    logic                    lk_evict;

    sacfl_tag_ram #(
        .DEPTH  (SETS),
        .WIDTH  (ROW_BITS),
        .ADDR_W (SET_BITS)
    ) u_tag_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (access_address[OFFSET_BITS +: SET_BITS]),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (set_reg),
        .wr_data (wr_row)
    );

    sacfl_lookup #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS),
        .WAY_BITS (WAY_BITS)
    ) u_lookup (
        .rd_row   (rd_row),
        .row_init (set_init_reg[set_reg]),
        .tag      (tag_reg),
        .mode     (replace_mode_reg),
        .now      (access_reg),
        .hit      (lk_hit),
        .way      (lk_way),
        .evict    (lk_evict),
        .wr_row   (wr_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    wr_en      = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            replace_mode_reg <= MODE_FIFO;
            set_init_reg     <= '0;
            access_reg       <= '0;
            miss_reg         <= '0;
            evict_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                replace_mode_reg <= cfg_data;
            end
            if (wr_en)
            begin
                set_init_reg[set_reg] <= 1'b1;
            end
            if (load_out)
            begin
                access_reg <= access_reg + STAMP_BITS'(1);
                miss_reg   <= miss_reg + COUNT_BITS'(!lk_hit);
                evict_reg  <= evict_reg + COUNT_BITS'(lk_evict);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            set_reg <= access_address[OFFSET_BITS +: SET_BITS];
            tag_reg <= access_address[ADDR_BITS-1 -: TAG_BITS];
        end
        if (load_out)
        begin
            is_hit_reg  <= lk_hit;
            way_reg     <= lk_way;
            replace_reg <= lk_evict;
        end
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign is_hit        = is_hit_reg;
    assign way_used      = way_reg;
    assign did_replace   = replace_reg;
    assign miss_total    = miss_reg;
    assign replace_total = evict_reg;

endmodule
